FILE: rtl/assert_macros.svh
// Assertion macros shared by the scrollback buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SLSB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SLSB_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/slsb_pkg.sv
// Types and constants of the serial line scrollback buffer.
package slsb_pkg;

  typedef enum logic [2:0] {
    ACT_RX     = 3'd0,
    ACT_UP     = 3'd1,
    ACT_DOWN   = 3'd2,
    ACT_TOGGLE = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  localparam logic [7:0]  CHAR_LF  = 8'h0A;
  localparam logic [7:0]  CHAR_CR  = 8'h0D;
  localparam logic [7:0]  PRINT_LO = 8'h20;
  localparam logic [7:0]  PRINT_HI = 8'h7E;
  localparam logic [7:0]  CHAR_DOT = 8'h2E;
  localparam logic [31:0] CTR_MAX  = 32'hFFFF_FFFF;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 104;

  // Status fields reported with every result word, after the action.
  typedef struct packed {
    logic        more_below;
    logic        more_above;
    logic [31:0] line_count;
    logic [31:0] byte_count;
    logic [5:0]  first_visible;
    logic        auto_follow;
    logic [5:0]  scroll_offset;
    logic [6:0]  retained_lines;
  } status_t;

endpackage

FILE: rtl/slsb_store.sv
// Character and line length memories of the line ring.
module slsb_store #(
  parameter int LINE_COLS  = 32,
  parameter int RING_LINES = 64,
  localparam int SW = $clog2(RING_LINES + 1),
  localparam int LW = $clog2(LINE_COLS)
) (
  input  logic          clk,
  input  logic          chr_we,
  input  logic [SW-1:0] chr_slot,
  input  logic [LW-1:0] chr_col,
  input  logic [7:0]    chr_data,
  input  logic          len_we,
  input  logic [SW-1:0] len_slot,
  input  logic [LW-1:0] len_data,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_slot,
  input  logic [LW-1:0] rd_col,
  output logic [7:0]    rd_chr,
  output logic [LW-1:0] rd_len
);

  localparam int CHR_DEPTH = (RING_LINES + 1) * (2 ** LW);

  logic [7:0]    chr_mem [0:CHR_DEPTH-1];
  logic [LW-1:0] len_mem [0:RING_LINES];

  always_ff @(posedge clk) begin
    if (chr_we) begin
      chr_mem[{chr_slot, chr_col}] <= chr_data;
    end
    if (rd_en) begin
      rd_chr <= chr_mem[{rd_slot, rd_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_slot] <= len_data;
    end
    if (rd_en) begin
      rd_len <= len_mem[rd_slot];
    end
  end

endmodule

FILE: rtl/slsb_ctrl.sv
// Line assembly, ring pointers, scroll state, counters and memory commands.
module slsb_ctrl #(
  parameter int LINE_COLS  = 32,
  parameter int RING_LINES = 64,
  parameter int VIEW_ROWS  = 7,
  localparam int SW = $clog2(RING_LINES + 1),
  localparam int LW = $clog2(LINE_COLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  slsb_pkg::action_t action,
  input  logic [7:0]        data_byte,
  input  logic [5:0]        line_index,
  input  logic [4:0]        column,
  output slsb_pkg::status_t status,
  output logic              rd_hit,
  output logic              chr_we,
  output logic [SW-1:0]     chr_slot,
  output logic [LW-1:0]     chr_col,
  output logic [7:0]        chr_data,
  output logic              len_we,
  output logic [SW-1:0]     len_slot,
  output logic [LW-1:0]     len_data,
  output logic              rd_en,
  output logic [SW-1:0]     rd_slot,
  output logic [LW-1:0]     rd_col
);

  import slsb_pkg::*;
  `include "assert_macros.svh"

  localparam int HW   = $clog2(RING_LINES + 1);
  localparam int CMPW = HW + 8;
  localparam int AW   = SW + 2;
  localparam int CIW  = (LW > 5) ? LW : 5;

  logic [SW-1:0] wr_r, wr_nxt, wr_inc;
  logic [HW-1:0] held_r, held_nxt;
  logic [HW-1:0] scroll_r, scroll_nxt;
  logic          follow_r, follow_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic [31:0]   lines_r, lines_nxt;

  logic            do_commit;
  logic            pl_full;
  logic            lf_commit;
  logic [CMPW-1:0] held_w, scroll_w, view_w;
  logic [CMPW-1:0] held_nw, scroll_nw;
  logic [AW-1:0]   sum_w, slot_w;
  logic [CIW-1:0]  col_ext;

  assign wr_inc  = (wr_r == SW'(RING_LINES)) ? '0 : wr_r + 1'b1;
  assign pl_full = (plen_r == LW'(LINE_COLS - 1));
  assign held_w  = CMPW'(held_r);
  assign scroll_w = CMPW'(scroll_r);
  assign view_w  = CMPW'(VIEW_ROWS);
  assign col_ext = CIW'(column);

  // Oldest retained line sits held lines behind the write slot; the ring has one
  // spare slot so the line being assembled never overwrites a retained one.
  assign sum_w  = AW'(wr_r) + AW'(RING_LINES + 1) - AW'(held_r) + AW'(line_index);
  assign slot_w = (sum_w >= AW'(RING_LINES + 1)) ? sum_w - AW'(RING_LINES + 1) : sum_w;

  always_comb begin
    wr_nxt     = wr_r;
    held_nxt   = held_r;
    scroll_nxt = scroll_r;
    follow_nxt = follow_r;
    plen_nxt   = plen_r;
    bytes_nxt  = bytes_r;
    lines_nxt  = lines_r;
    do_commit  = 1'b0;
    chr_we     = 1'b0;
    chr_slot   = wr_r;
    chr_col    = plen_r;
    chr_data   = data_byte;
    rd_en      = 1'b0;
    rd_hit     = 1'b0;
    rd_slot    = slot_w[SW-1:0];
    rd_col     = col_ext[LW-1:0];

    if (accept) begin
      case (action)
        ACT_RX: begin
          if (bytes_r != CTR_MAX) begin
            bytes_nxt = bytes_r + 32'd1;
          end
          if (data_byte == CHAR_LF) begin
            do_commit = (plen_r != '0);
            plen_nxt  = '0;
          end else if (data_byte != CHAR_CR) begin
            do_commit = pl_full;
            chr_we    = 1'b1;
            chr_slot  = pl_full ? wr_inc : wr_r;
            chr_col   = pl_full ? '0 : plen_r;
            chr_data  = (data_byte >= PRINT_LO && data_byte <= PRINT_HI) ?
                        data_byte : CHAR_DOT;
            plen_nxt  = chr_col + 1'b1;
          end
        end
        ACT_UP: begin
          if (held_w > view_w && scroll_w + view_w < held_w) begin
            scroll_nxt = scroll_r + 1'b1;
            follow_nxt = 1'b0;
          end
        end
        ACT_DOWN: begin
          if (scroll_r != '0) begin
            scroll_nxt = scroll_r - 1'b1;
            if (scroll_r == HW'(1)) begin
              follow_nxt = 1'b1;
            end
          end
        end
        ACT_TOGGLE: begin
          follow_nxt = !follow_r;
          if (!follow_r) begin
            scroll_nxt = '0;
          end
        end
        ACT_CLEAR: begin
          wr_nxt     = '0;
          held_nxt   = '0;
          scroll_nxt = '0;
          follow_nxt = 1'b1;
          plen_nxt   = '0;
          bytes_nxt  = '0;
          lines_nxt  = '0;
        end
        ACT_READ: begin
          rd_en  = 1'b1;
          rd_hit = (CMPW'(line_index) < held_w);
        end
        default: begin
        end
      endcase

      if (do_commit) begin
        wr_nxt = wr_inc;
        if (held_r != HW'(RING_LINES)) begin
          held_nxt = held_r + 1'b1;
        end
        if (lines_r != CTR_MAX) begin
          lines_nxt = lines_r + 32'd1;
        end
        if (follow_r) begin
          scroll_nxt = '0;
        end
      end
    end
  end

  assign len_we   = do_commit;
  assign len_slot = wr_r;
  assign len_data = plen_r;

  assign held_nw   = CMPW'(held_nxt);
  assign scroll_nw = CMPW'(scroll_nxt);

  always_comb begin
    status.retained_lines = 7'(held_nxt);
    status.scroll_offset  = 6'(scroll_nxt);
    status.auto_follow    = follow_nxt;
    status.byte_count     = bytes_nxt;
    status.line_count     = lines_nxt;
    status.more_below     = (held_nw > view_w + scroll_nw);
    status.more_above     = (scroll_nxt != '0) && (held_nw > view_w);
    status.first_visible  = status.more_below ? 6'(held_nw - view_w - scroll_nw) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= '0;
      held_r   <= '0;
      scroll_r <= '0;
      follow_r <= 1'b1;
      plen_r   <= '0;
      bytes_r  <= '0;
      lines_r  <= '0;
    end else begin
      wr_r     <= wr_nxt;
      held_r   <= held_nxt;
      scroll_r <= scroll_nxt;
      follow_r <= follow_nxt;
      plen_r   <= plen_nxt;
      bytes_r  <= bytes_nxt;
      lines_r  <= lines_nxt;
    end
  end

  assign lf_commit = accept && action == ACT_RX && data_byte == CHAR_LF &&
                     plen_r != '0;

  `SLSB_ASSERT_CLK(a_scroll_bound, scroll_r != '0 |-> scroll_w + view_w <= held_w, "bad scroll")
  `SLSB_ASSERT_CLK(a_commit_moves, lf_commit |=> wr_r != $past(wr_r), "line feed did not commit")
  `SLSB_ASSERT_ANY(a_reset_state, !rst_n |=> held_r == '0 && follow_r && plen_r == '0, "bad reset")

endmodule

FILE: rtl/serial_line_scrollback_buffer.sv
// Top level of the serial line scrollback buffer with its two-stage result pipeline.
// Each accepted input word yields exactly one result word. At acceptance the synchronous
// read of the character and line length memories is registered alongside stage one, and
// the result moves into the output register once that is free. A new word is taken every cycle
// while results are taken; when out_tready stays low, one more word waits in stage one
// and in_tready then drops until the output register empties. Every action, including a
// line commit, costs one write to each memory at most, so the single write port per
// memory is what sets this rate. The memories need no clearing pass after reset, since
// a line is only read once it has been committed. The status fields of a result show
// the state after its action.
module serial_line_scrollback_buffer #(
  parameter int LINE_COLS  = 32,
  parameter int RING_LINES = 64,
  parameter int VIEW_ROWS  = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // data_byte[7:0], line_index[13:8], column[18:14], zero fill above
  input  logic [slsb_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[2:0]
  input  logic [slsb_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // char_out[7:0], line_length[12:8], retained_lines[19:13], scroll_offset[25:20],
  // auto_follow[26], first_visible[32:27], byte_count[64:33], line_count[96:65],
  // more_above[97], more_below[98], zero fill above
  output logic [slsb_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  import slsb_pkg::*;
  `include "assert_macros.svh"

  localparam int SW  = $clog2(RING_LINES + 1);
  localparam int LW  = $clog2(LINE_COLS);
  localparam int CCW = (LW > 5) ? LW : 5;

  logic          accept;
  logic          s1_adv;
  logic          s1_move;
  action_t       action;
  status_t       status;
  logic          rd_hit;
  logic          chr_we, len_we, rd_en;
  logic [SW-1:0] chr_slot, len_slot, rd_slot;
  logic [LW-1:0] chr_col, len_data, rd_col;
  logic [7:0]    chr_data, rd_chr;
  logic [LW-1:0] rd_len;

  logic          s1_v_r, s1_v_nxt;
  status_t       s1_status_r;
  logic          s1_hit_r;
  logic [4:0]    s1_col_r;
  logic          out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [CCW-1:0] col_c, len_c;
  logic [7:0]     char_res;
  logic [4:0]     len_res;

  assign action    = action_t'(in_tuser);
  assign s1_adv    = !out_v_r || out_tready;
  assign s1_move   = s1_v_r && s1_adv;
  assign in_tready = !s1_v_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  slsb_ctrl #(
    .LINE_COLS (LINE_COLS),
    .RING_LINES(RING_LINES),
    .VIEW_ROWS (VIEW_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (action),
    .data_byte (in_tdata[7:0]),
    .line_index(in_tdata[13:8]),
    .column    (in_tdata[18:14]),
    .status    (status),
    .rd_hit    (rd_hit),
    .chr_we    (chr_we),
    .chr_slot  (chr_slot),
    .chr_col   (chr_col),
    .chr_data  (chr_data),
    .len_we    (len_we),
    .len_slot  (len_slot),
    .len_data  (len_data),
    .rd_en     (rd_en),
    .rd_slot   (rd_slot),
    .rd_col    (rd_col)
  );

  slsb_store #(
    .LINE_COLS (LINE_COLS),
    .RING_LINES(RING_LINES)
  ) u_store (
    .clk     (clk),
    .chr_we  (chr_we),
    .chr_slot(chr_slot),
    .chr_col (chr_col),
    .chr_data(chr_data),
    .len_we  (len_we),
    .len_slot(len_slot),
    .len_data(len_data),
    .rd_en   (rd_en),
    .rd_slot (rd_slot),
    .rd_col  (rd_col),
    .rd_chr  (rd_chr),
    .rd_len  (rd_len)
  );

  // The memory read data is valid in the cycle after acceptance, alongside stage one.
  assign col_c    = CCW'(s1_col_r);
  assign len_c    = CCW'(rd_len);
  assign char_res = (s1_hit_r && col_c < len_c) ? rd_chr : 8'd0;
  assign len_res  = s1_hit_r ? len_c[4:0] : 5'd0;

  assign s1_v_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
      s1_hit_r    <= rd_hit;
      s1_col_r    <= in_tdata[18:14];
    end
    if (s1_move) begin
      out_data_r <= {5'd0,
                     s1_status_r.more_below,
                     s1_status_r.more_above,
                     s1_status_r.line_count,
                     s1_status_r.byte_count,
                     s1_status_r.first_visible,
                     s1_status_r.auto_follow,
                     s1_status_r.scroll_offset,
                     s1_status_r.retained_lines,
                     len_res,
                     char_res};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  `SLSB_ASSERT_CLK(a_accept_fills, accept |=> s1_v_r, "accepted word lost before stage one")
  `SLSB_ASSERT_CLK(a_stage_moves, s1_move && !accept |=> out_v_r && !s1_v_r, "stage one stuck")
  `SLSB_ASSERT_CLK(a_out_hold, out_v_r && !out_tready |=> out_v_r && $stable(out_data_r), "lost")

endmodule

FILE: tb/slsb_result_checker.sv
// Checker for the scrollback buffer: watches both channels, predicts and compares results.
module slsb_result_checker #(
  parameter int LINE_COLS  = 32,
  parameter int RING_LINES = 64,
  parameter int VIEW_ROWS  = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [slsb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [slsb_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [slsb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                                error_count,
  output int                                pending
);
  import slsb_pkg::*;

  // Same layout as the low bits of out_tdata.
  typedef struct packed {
    status_t    status;
    logic [4:0] line_length;
    logic [7:0] char_out;
  } view_word_t;

  logic [7:0] ring_chars [RING_LINES][LINE_COLS];
  int         ring_len [RING_LINES];
  logic [7:0] open_chars [LINE_COLS];
  int         open_len;
  int         next_slot;
  int         held;
  int         scroll;
  logic       follow;
  logic [31:0] byte_total;
  logic [31:0] line_total;

  view_word_t awaited_q[$];

  function automatic void reset_model();
    open_len = 0;
    next_slot = 0;
    held = 0;
    scroll = 0;
    follow = 1'b1;
    byte_total = '0;
    line_total = '0;
  endfunction

  function automatic void commit_open_line();
    if (open_len == 0) return;
    for (int i = 0; i < open_len; i++) ring_chars[next_slot][i] = open_chars[i];
    ring_len[next_slot] = open_len;
    next_slot = (next_slot + 1) % RING_LINES;
    if (held < RING_LINES) held++;
    if (line_total != CTR_MAX) line_total++;
    open_len = 0;
    if (follow) scroll = 0;
  endfunction

  function automatic void take_rx_byte(logic [7:0] b);
    logic [7:0] c;
    c = b;
    if (byte_total != CTR_MAX) byte_total++;
    if (c == CHAR_LF) begin
      commit_open_line();
      return;
    end
    if (c == CHAR_CR) return;
    if (c < PRINT_LO || c > PRINT_HI) c = CHAR_DOT;
    // A full open line is pushed out before the new character starts the next one.
    if (open_len >= LINE_COLS - 1) commit_open_line();
    open_chars[open_len] = c;
    open_len++;
  endfunction

  function automatic view_word_t predict_view(logic [2:0] act, logic [7:0] data,
                                              logic [5:0] idx, logic [4:0] col);
    view_word_t w;
    int slot;
    int first_row;
    w = '0;
    case (act)
      ACT_RX: take_rx_byte(data);
      ACT_UP: begin
        if (held > VIEW_ROWS && scroll < held - VIEW_ROWS) begin
          scroll++;
          follow = 1'b0;
        end
      end
      ACT_DOWN: begin
        if (scroll > 0) begin
          scroll--;
          if (scroll == 0) follow = 1'b1;
        end
      end
      ACT_TOGGLE: begin
        follow = ~follow;
        if (follow) scroll = 0;
      end
      ACT_CLEAR: reset_model();
      ACT_READ: begin
        if (int'(idx) < held) begin
          slot = (next_slot + RING_LINES - held + int'(idx)) % RING_LINES;
          w.line_length = 5'(ring_len[slot]);
          if (int'(col) < ring_len[slot]) w.char_out = ring_chars[slot][col];
        end
      end
      default: ;
    endcase
    first_row = (held > VIEW_ROWS + scroll) ? held - VIEW_ROWS - scroll : 0;
    w.status.retained_lines = 7'(held);
    w.status.scroll_offset  = 6'(scroll);
    w.status.auto_follow    = follow;
    w.status.first_visible  = 6'(first_row);
    w.status.byte_count     = byte_total;
    w.status.line_count     = line_total;
    w.status.more_above     = (scroll > 0 && held > VIEW_ROWS);
    w.status.more_below     = (held > VIEW_ROWS + scroll);
    return w;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
    end
  endfunction

  function automatic void check_word(view_word_t want, view_word_t seen);
    check_field("char_out", 32'(want.char_out), 32'(seen.char_out));
    check_field("line_length", 32'(want.line_length), 32'(seen.line_length));
    check_field("retained_lines", 32'(want.status.retained_lines),
                32'(seen.status.retained_lines));
    check_field("scroll_offset", 32'(want.status.scroll_offset),
                32'(seen.status.scroll_offset));
    check_field("auto_follow", 32'(want.status.auto_follow),
                32'(seen.status.auto_follow));
    check_field("first_visible", 32'(want.status.first_visible),
                32'(seen.status.first_visible));
    check_field("byte_count", want.status.byte_count, seen.status.byte_count);
    check_field("line_count", want.status.line_count, seen.status.line_count);
    check_field("more_above", 32'(want.status.more_above), 32'(seen.status.more_above));
    check_field("more_below", 32'(want.status.more_below), 32'(seen.status.more_below));
  endfunction

  always @(posedge clk) begin
    view_word_t seen;
    if (!rst_n) begin
      reset_model();
      awaited_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata[$bits(view_word_t)-1:0];
        if (awaited_q.size() == 0) begin
          error_count++;
          $display("%0t: result word with none expected, expected nothing, got %h",
                   $time, seen);
        end else begin
          check_word(awaited_q.pop_front(), seen);
        end
      end
      if (in_tvalid && in_tready)
        awaited_q.push_back(predict_view(in_tuser, in_tdata[7:0], in_tdata[13:8],
                                         in_tdata[18:14]));
    end
    pending = awaited_q.size();
  end

endmodule

FILE: tb/tb_serial_line_scrollback_buffer.sv
// Testbench top for the serial line scrollback buffer: clock, reset, stimulus and verdict.
module tb_serial_line_scrollback_buffer;
  import slsb_pkg::*;

  // Action codes the block does not define; they must leave the state alone.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  localparam int RANDOM_WORDS   = 850;
  localparam int WARMUP_WORDS   = 150;
  localparam int TIMEOUT_CYCLES = 200000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata;
  logic [IN_TUSER_W-1:0]    in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_TDATA_W-1:0]   out_tdata;

  int error_count;
  int pending;
  int words_sent;
  bit tx_quiet;
  bit rx_quiet;

  always #5 clk = ~clk;

  serial_line_scrollback_buffer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  slsb_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_count (error_count),
    .pending     (pending)
  );

  // Result side: after each accepted word, hold ready low for a random number of cycles.
  initial begin
    int stall;
    out_tready = 1'b0;
    stall = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
      if (out_tvalid && out_tready) stall = rx_quiet ? 0 : $urandom_range(0, 4);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("RESULT: ERROR");
    $finish;
  end

  // Called and returns at a falling edge.
  task automatic send_word(logic [2:0] act, logic [7:0] data, logic [5:0] idx,
                           logic [4:0] col);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, col, idx, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_rx(logic [7:0] b);
    send_word(ACT_RX, b, 6'($urandom), 5'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // One line of text, usually closed by a line feed; long ones overflow and commit early.
  task automatic send_text_line(bit short_only);
    int n;
    int pick;
    pick = $urandom_range(0, 9);
    if (short_only) n = $urandom_range(1, 3);
    else if (pick < 7) n = $urandom_range(0, 5);
    else if (pick < 9) n = $urandom_range(6, 30);
    else n = $urandom_range(31, 40);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0 && !short_only) send_rx(CHAR_CR);
      else if (pick < 3 && !short_only) send_rx(8'($urandom_range(0, 255)));
      else send_rx(8'($urandom_range(PRINT_LO, PRINT_HI)));
    end
    if (short_only || $urandom_range(0, 9) != 0) send_rx(CHAR_LF);
  endtask

  task automatic send_scroll_burst();
    int ups;
    int downs;
    ups = $urandom_range(1, 64);
    downs = $urandom_range(0, ups);
    repeat (ups) send_word(ACT_UP, 8'($urandom), 6'($urandom), 5'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_word(ACT_TOGGLE, 8'($urandom), 6'($urandom), 5'($urandom));
    repeat (downs) send_word(ACT_DOWN, 8'($urandom), 6'($urandom), 5'($urandom));
  endtask

  task automatic send_reads();
    int n;
    logic [5:0] idx;
    logic [4:0] col;
    n = $urandom_range(1, 6);
    repeat (n) begin
      idx = 6'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 7));
      col = 5'($urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 5));
      send_word(ACT_READ, 8'($urandom), idx, col);
    end
  endtask

  task automatic send_noise_word();
    logic [2:0] act;
    case ($urandom_range(0, 6))
      0: act = ACT_RX;
      1: act = ACT_UP;
      2: act = ACT_DOWN;
      3: act = ACT_TOGGLE;
      4: act = ACT_READ;
      5: act = ACT_SPARE_A;
      default: act = ACT_SPARE_B;
    endcase
    send_word(act, 8'($urandom), 6'($urandom), 5'($urandom));
  endtask

  initial begin
    int base;
    int pick;
    bit paused;
    bit cleared;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    words_sent = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    paused = 1'b0;
    cleared = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Empty buffer: reads and scrolling have nothing to act on; the follow toggle flips and flips back.
    send_word(ACT_READ, 8'h00, 6'd0, 5'd0);
    send_word(ACT_DOWN, 8'hFF, 6'h3F, 5'h1F);
    send_word(ACT_UP, 8'h00, 6'd0, 5'd0);
    send_word(ACT_TOGGLE, 8'h00, 6'd0, 5'd0);
    send_word(ACT_TOGGLE, 8'h00, 6'd0, 5'd0);
    // Printable edges and bytes that turn into dots, a dropped CR, then a commit.
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(PRINT_HI);
    send_rx(PRINT_LO);
    send_rx(8'h1F);
    send_rx(8'h7F);
    send_rx(CHAR_CR);
    send_rx(CHAR_LF);
    send_rx(CHAR_LF);
    send_word(ACT_READ, 8'h00, 6'd0, 5'd0);
    send_word(ACT_READ, 8'h00, 6'd0, 5'd31);
    send_word(ACT_READ, 8'h00, 6'd63, 5'd0);
    send_word(ACT_SPARE_A, 8'hFF, 6'h3F, 5'h1F);
    send_word(ACT_SPARE_B, 8'h00, 6'd0, 5'd0);
    send_word(ACT_CLEAR, 8'h00, 6'd0, 5'd0);
    wait_drained();

    base = words_sent;
    while (words_sent < base + RANDOM_WORDS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (!paused && words_sent >= base + 400) begin
        wait_drained();
        paused = 1'b1;
      end
      if (!cleared && words_sent >= base + 720) begin
        wait_drained();
        send_word(ACT_CLEAR, 8'($urandom), 6'($urandom), 5'($urandom));
        cleared = 1'b1;
      end
      // Fill the ring with short lines first so that wrap and deep scrolling are reached.
      if (words_sent < base + WARMUP_WORDS) begin
        send_text_line(1'b1);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) send_text_line(1'b0);
        else if (pick < 70) send_scroll_burst();
        else if (pick < 85) send_reads();
        else if (pick < 90) send_word(ACT_TOGGLE, 8'($urandom), 6'($urandom), 5'($urandom));
        else send_noise_word();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
